// ===== rtl/gklpd_pkg.sv =====
package gklpd_pkg;

    localparam int NUM_KEYS   = 12;
    localparam int TIME_WIDTH = 32;
    localparam int KEY_W      = 4;
    localparam int LPT_W      = 16;
    localparam int LINES      = (NUM_KEYS < 12) ? NUM_KEYS : 12;

    // hold time after reset, 0.6 s at a 1 kHz tick
    localparam logic [LPT_W-1:0] LPT_RESET = LPT_W'(600);

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_SCAN = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        EV_KEY  = 2'd0,
        EV_MOD  = 2'd1,
        EV_SYNC = 2'd2
    } ev_kind_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_TIMING = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

    typedef struct packed {
        logic              op;
        logic [11:0]       pin_levels;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]        event_kind;
        logic [KEY_W-1:0]  key_index;
        logic              pressed;
        logic              last;
    } out_beat_t;

    typedef struct packed {
        logic [1:0]            phase;
        logic [TIME_WIDTH-1:0] deadline;
    } key_entry_t;

endpackage

// ===== rtl/gklpd_ram.sv =====
module gklpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/gpio_key_long_press_detector.sv =====
// Long/short press classifier for twelve active-low key lines. A tick beat (op = 0)
// advances a free-running 32-bit time counter and produces nothing. A scan beat
// (op = 1) samples all lines and visits keys 0..11 in turn through a per-key state
// RAM (phase + deadline, one read and one write port, registered read): each key is
// read in a read state and then evaluated in an evaluate state. A long press yields
// five result beats and a short one three; the closing sync of the scan leaves in
// the flush state. A newly pressed key records deadline = now + long_press_ticks; a
// key held past its deadline emits modifier down, key down, key up, modifier up,
// sync and is marked done; a release of a still-timing key emits that long burst if
// the deadline has passed (wrap-safe compare) or key down, key up, sync otherwise.
// The last result beat of a scan carries last = 1. Results pass through an output
// register, so a new input beat is taken while a result still waits. The user must
// write long_press_ticks through cfg_we / cfg_wdata only while the block is idle;
// the block itself does not enforce this. It resets to 600.
module gpio_key_long_press_detector
    import gklpd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // configuration
    input  logic              cfg_we,
    input  logic [LPT_W-1:0]  cfg_wdata,
    // input beats
    input  logic              s_valid,
    output logic              s_ready,
    input  in_beat_t          s_data,
    // result beats
    output logic              m_valid,
    input  logic              m_ready,
    output out_beat_t         m_data
);

    localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(LINES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EVAL,
        S_BURST,
        S_FLUSH
    } state_t;

    // sequencer state
    state_t                state_reg, state_next;
    logic [KEY_W-1:0]      idx_reg, idx_next;
    logic [11:0]           pins_reg, pins_next;
    logic                  long_reg, long_next;       // current burst is the long form
    logic [1:0]            step_reg, step_next;
    logic                  hold_reg, hold_next;       // a sync beat is held back
    logic [KEY_W-1:0]      hold_key_reg, hold_key_next;
    logic [TIME_WIDTH-1:0] now_reg, now_next;
    logic [LPT_W-1:0]      lpt_reg, lpt_next;
    logic [NUM_KEYS-1:0]   vld_reg, vld_next;         // entry written since reset
    logic                  m_valid_reg, m_valid_next;
    out_beat_t             m_data_reg, m_data_next;

    // state RAM
    logic                  ram_we;
    key_entry_t            ram_wdata;
    key_entry_t            ram_rdata;
    logic                  ram_re;

    // evaluate-stage decode
    logic                  pin_active;
    logic [1:0]            cur_phase;
    logic [TIME_WIDTH-1:0] since;
    logic                  passed;
    logic                  out_free;
    logic                  step_final;
    out_beat_t             ev;

    gklpd_ram #(
        .WIDTH ($bits(key_entry_t)),
        .DEPTH (NUM_KEYS)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign ram_re  = (state_reg == S_RD);

    // never-written entries read as idle
    assign pin_active = ~pins_reg[idx_reg];
    assign cur_phase  = vld_reg[idx_reg] ? ram_rdata.phase : PH_IDLE;
    // wrap-safe "deadline passed": now - deadline nonzero and not negative
    assign since      = now_reg - ram_rdata.deadline;
    assign passed     = (since != '0) && !since[TIME_WIDTH-1];

    assign out_free  = !m_valid_reg || m_ready;

    // burst event table, sync comes separately from the hold slot
    always_comb begin
        ev.key_index = idx_reg;
        ev.last      = 1'b0;
        step_final   = 1'b0;
        if (long_reg) begin
            case (step_reg)
                2'd0:    begin ev.event_kind = EV_MOD; ev.pressed = 1'b1; end
                2'd1:    begin ev.event_kind = EV_KEY; ev.pressed = 1'b1; end
                2'd2:    begin ev.event_kind = EV_KEY; ev.pressed = 1'b0; end
                default: begin
                    ev.event_kind = EV_MOD;
                    ev.pressed    = 1'b0;
                    step_final    = 1'b1;
                end
            endcase
        end else begin
            ev.event_kind = EV_KEY;
            ev.pressed    = (step_reg == 2'd0);
            step_final    = (step_reg != 2'd0);
        end
    end

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        pins_next     = pins_reg;
        long_next     = long_reg;
        step_next     = step_reg;
        hold_next     = hold_reg;
        hold_key_next = hold_key_reg;
        now_next      = now_reg;
        lpt_next      = cfg_we ? cfg_wdata : lpt_reg;
        vld_next      = vld_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        ram_we        = 1'b0;
        ram_wdata     = ram_rdata;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_data.op == OP_TICK) begin
                        now_next = now_reg + TIME_WIDTH'(1);
                    end else begin
                        pins_next  = s_data.pin_levels;
                        idx_next   = '0;
                        state_next = S_RD;
                    end
                end
            end

            S_RD: begin
                state_next = S_EVAL;
            end

            S_EVAL: begin
                // default: move on to the next key
                if (idx_reg == LAST_KEY) begin
                    state_next = S_FLUSH;
                end else begin
                    idx_next   = idx_reg + KEY_W'(1);
                    state_next = S_RD;
                end
                step_next = '0;
                if (pin_active) begin
                    if (cur_phase == PH_IDLE) begin
                        // first scan of a press only arms the deadline
                        ram_we             = 1'b1;
                        ram_wdata.phase    = PH_TIMING;
                        ram_wdata.deadline = now_reg + TIME_WIDTH'(lpt_reg);
                    end else if (cur_phase == PH_TIMING && passed) begin
                        ram_we          = 1'b1;
                        ram_wdata.phase = PH_DONE;
                        long_next       = 1'b1;
                        idx_next        = idx_reg;
                        state_next      = S_BURST;
                    end
                end else if (cur_phase != PH_IDLE) begin
                    ram_we          = 1'b1;
                    ram_wdata.phase = PH_IDLE;
                    if (cur_phase == PH_TIMING) begin
                        long_next  = passed;
                        idx_next   = idx_reg;
                        state_next = S_BURST;
                    end
                end
                if (ram_we) begin
                    vld_next[idx_reg] = 1'b1;
                end
            end

            S_BURST: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (hold_reg) begin
                        // a later burst follows, so the held sync is not the last beat
                        m_data_next.event_kind = EV_SYNC;
                        m_data_next.key_index  = hold_key_reg;
                        m_data_next.pressed    = 1'b0;
                        m_data_next.last       = 1'b0;
                        hold_next              = 1'b0;
                    end else begin
                        m_data_next = ev;
                        step_next   = step_reg + 2'd1;
                        if (step_final) begin
                            hold_next     = 1'b1;
                            hold_key_next = idx_reg;
                            if (idx_reg == LAST_KEY) begin
                                state_next = S_FLUSH;
                            end else begin
                                idx_next   = idx_reg + KEY_W'(1);
                                state_next = S_RD;
                            end
                        end
                    end
                end
            end

            S_FLUSH: begin
                if (!hold_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.event_kind = EV_SYNC;
                    m_data_next.key_index  = hold_key_reg;
                    m_data_next.pressed    = 1'b0;
                    m_data_next.last       = 1'b1;
                    hold_next              = 1'b0;
                    state_next             = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            pins_reg     <= '1;
            long_reg     <= 1'b0;
            step_reg     <= '0;
            hold_reg     <= 1'b0;
            hold_key_reg <= '0;
            now_reg      <= '0;
            lpt_reg      <= LPT_RESET;
            vld_reg      <= '0;
            m_valid_reg  <= 1'b0;
            m_data_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            pins_reg     <= pins_next;
            long_reg     <= long_next;
            step_reg     <= step_next;
            hold_reg     <= hold_next;
            hold_key_reg <= hold_key_next;
            now_reg      <= now_next;
            lpt_reg      <= lpt_next;
            vld_reg      <= vld_next;
            m_valid_reg  <= m_valid_next;
            m_data_reg   <= m_data_next;
        end
    end

endmodule

// ===== rtl/gklpd_checker.sv =====
module gklpd_checker
    import gklpd_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input out_beat_t         m_data
);

    // stalled result beat holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // a burst always closes with sync, so only sync may end a scan
    a_last_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.last |-> m_data.event_kind == EV_SYNC)
        else $error("last beat is not a sync marker");

    a_sync_up: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.event_kind == EV_SYNC |-> !m_data.pressed)
        else $error("sync marker flagged as pressed");

    a_key_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.key_index < KEY_W'(LINES))
        else $error("key index beyond scanned lines");

    // a key down event is always followed by its key up in the next beat
    a_down_up: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.event_kind == EV_KEY && m_data.pressed
        |=> !m_valid || (m_data.event_kind == EV_KEY && !m_data.pressed))
        else $error("key down not followed by key up");

endmodule

bind gpio_key_long_press_detector gklpd_checker u_gklpd_checker (.*);
